FILE: rtl/core/pct_pkg.sv
`default_nettype none

package pct_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // utf-8 replacement character u+fffd
  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT_PLUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_REPL,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       is_end;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pct_in_if.sv
`default_nettype none

interface pct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_end;

  modport source (output valid, output char_in, output is_end, input ready);
  modport sink   (input valid, input char_in, input is_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pct_out_if.sv
`default_nettype none

interface pct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       run_last;
  logic       string_done;
  logic       error;

  modport source (output valid, output byte_out, output run_last, output string_done,
                  output error, input ready);
  modport sink   (input valid, input byte_out, input run_last, input string_done,
                  input error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pct_front.sv
`default_nettype none

module pct_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   char_in,
  input  wire logic         is_end,
  input  wire logic         convert_plus,
  input  wire logic         strict_mode,
  input  wire logic         q_full,
  output logic              push,
  output pct_pkg::cmd_t     push_cmd
);
  import pct_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIGIT1,
    PH_DIGIT2,
    PH_DROP
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       digit_bad_r, digit_bad_nxt;
  logic       accept;
  logic       hex_bad;
  logic [3:0] hex_val;

  // hex digit decode, either case
  always_comb begin
    hex_bad = 1'b0;
    hex_val = 4'd0;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      hex_val = 4'(char_in - 8'h30);
    end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
      hex_val = 4'(HEX_ALPHA_BASE + (char_in - 8'h61));
    end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
      hex_val = 4'(HEX_ALPHA_BASE + (char_in - 8'h41));
    end else begin
      hex_bad = 1'b1;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt       = phase_r;
    high_nibble_nxt = high_nibble_r;
    digit_bad_nxt   = digit_bad_r;
    push            = 1'b0;
    push_cmd.kind   = CMD_BYTE;
    push_cmd.data   = char_in;
    push_cmd.is_end = is_end;
    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (char_in == CHAR_PERCENT) begin
            high_nibble_nxt = 4'd0;
            digit_bad_nxt   = 1'b0;
            if (is_end) begin
              push      = 1'b1;
              push_cmd.kind = strict_mode ? CMD_ERR : CMD_REPL;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_DIGIT1;
            end
          end else begin
            push = 1'b1;
            if (convert_plus && char_in == CHAR_PLUS) begin
              push_cmd.data = CHAR_SPACE;
            end
          end
        end
        PH_DIGIT1: begin
          if (is_end) begin
            push            = 1'b1;
            push_cmd.kind   = strict_mode ? CMD_ERR : CMD_REPL;
            high_nibble_nxt = 4'd0;
            digit_bad_nxt   = 1'b0;
            phase_nxt       = PH_IDLE;
          end else begin
            digit_bad_nxt   = hex_bad;
            high_nibble_nxt = hex_bad ? 4'd0 : hex_val;
            phase_nxt       = PH_DIGIT2;
          end
        end
        PH_DIGIT2: begin
          push            = 1'b1;
          high_nibble_nxt = 4'd0;
          digit_bad_nxt   = 1'b0;
          if (digit_bad_r || hex_bad) begin
            if (strict_mode) begin
              push_cmd.kind = CMD_ERR;
              phase_nxt     = is_end ? PH_IDLE : PH_DROP;
            end else begin
              push_cmd.kind = CMD_REPL;
              phase_nxt     = PH_IDLE;
            end
          end else begin
            push_cmd.data = {high_nibble_r, hex_val};
            phase_nxt     = PH_IDLE;
          end
        end
        PH_DROP: begin
          if (is_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      high_nibble_r <= 4'd0;
      digit_bad_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      high_nibble_r <= high_nibble_nxt;
      digit_bad_r   <= digit_bad_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pct_queue.sv
`default_nettype none

module pct_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pct_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output pct_pkg::cmd_t       head_cmd
);
  import pct_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pct_back.sv
`default_nettype none

module pct_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire pct_pkg::cmd_t  head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          byte_out,
  output logic                run_last,
  output logic                string_done,
  output logic                error
);
  import pct_pkg::*;

  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       done_r, done_nxt;
  logic       err_r, err_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       load;

  // output slot free or being drained this cycle
  assign load = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    sub_nxt  = sub_r;
    pop      = 1'b0;
    byte_nxt = head_cmd.data;
    last_nxt = 1'b1;
    done_nxt = head_cmd.is_end;
    err_nxt  = 1'b0;
    case (head_cmd.kind)
      CMD_BYTE: begin
        pop = load;
      end
      CMD_ERR: begin
        pop      = load;
        byte_nxt = 8'h00;
        done_nxt = 1'b1;
        err_nxt  = 1'b1;
      end
      CMD_REPL: begin
        case (sub_r)
          2'd0: begin
            byte_nxt = REPL_BYTE0;
            last_nxt = 1'b0;
            done_nxt = 1'b0;
          end
          2'd1: begin
            byte_nxt = REPL_BYTE1;
            last_nxt = 1'b0;
            done_nxt = 1'b0;
          end
          default: begin
            byte_nxt = REPL_BYTE2;
          end
        endcase
        if (load) begin
          if (sub_r == 2'd2) begin
            pop     = 1'b1;
            sub_nxt = 2'd0;
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      default: begin
        pop = load;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign byte_out    = byte_r;
  assign run_last    = last_r;
  assign string_done = done_r;
  assign error       = err_r;

endmodule

`default_nettype wire

FILE: rtl/core/percent_decoder_top.sv
`default_nettype none

// channel    dir  payload                                    accepted on
// in_chan    in   char_in[7:0], is_end                       valid && ready
// out_chan   out  byte_out[7:0], run_last, string_done, error valid && ready
// cfg_*      in   cfg_index[0], cfg_wdata[0]                 cfg_we
//
// one request per cycle in unless the queue is full; one result per cycle out
// from a registered slot while out_ready is high; a replacement escape is sent
// as the three bytes EF BF BD; front and back are split by a small command
// queue, so in_ready drops only when the queue is full
// rst_n is synchronous; it clears the escape state, the queue and out valid,
// and loads convert_plus 0, strict_mode 1

module percent_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pct_in_if.sink                          in_chan,
  pct_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [pct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                       cfg_wdata
);
  import pct_pkg::*;

  logic convert_plus_r;
  logic strict_mode_r;
  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_plus_r <= 1'b0;
      strict_mode_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONVERT_PLUS: convert_plus_r <= cfg_wdata;
        REG_STRICT_MODE:  strict_mode_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pct_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .char_in      (in_chan.char_in),
    .is_end       (in_chan.is_end),
    .convert_plus (convert_plus_r),
    .strict_mode  (strict_mode_r),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  pct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  pct_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .byte_out    (out_chan.byte_out),
    .run_last    (out_chan.run_last),
    .string_done (out_chan.string_done),
    .error       (out_chan.error)
  );

endmodule

`default_nettype wire
